### sv/lebu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lebu_pkg;

    localparam int OP_W      = 3;
    localparam int CHAR_W    = 21;
    localparam int RIDX_W    = 6;
    localparam int POS_W     = 7;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;
    localparam logic [POS_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_LEFT      = 3'd0,
        OP_RIGHT     = 3'd1,
        OP_INSERT    = 3'd2,
        OP_DEL_LEFT  = 3'd3,
        OP_DEL_RIGHT = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_LEFT,
        CMD_RIGHT
    } cell_cmd_t;

    typedef enum logic [1:0] {
        TAP_HOLD,
        TAP_LOAD,
        TAP_CLEAR,
        TAP_SHIFT
    } tap_cmd_t;

    typedef struct packed {
        cell_cmd_t data_cmd;
        tap_cmd_t  tap_cmd;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/line_edit_buffer_unit.sv
// Line edit buffer: one editable line of code points with a cursor.
// s_ channel: one edit operation per item. s_tdata = op[2:0], code_point[23:3],
// read_index[29:24], zero padding above.
// m_ channel: one result per item. m_tdata = cursor_position[6:0],
// line_length[13:7], read_char[34:14], took_effect[35], zero padding above.
// cfg_ channel: writes length_limit (cfg_data); always ready, write it while idle.
// The line sits in a row of cells; insert and delete shift the cells in parallel.
// Moves, inserts, deletes, spare op codes and reads that miss give m_tvalid in
// the cycle after the item is taken. A read that hits walks the read tap chain
// towards cell 0 one cell per cycle before its result is given.
// One item is in flight at a time: s_tready rises again the cycle after the
// result is taken, so no new item is taken while one is still in flight.
// When m_tready is low the result holds on m_tdata and no new item is taken.
// Reset clears the cursor, the length and the handshake state and sets the
// limit to 64; the cell contents are not cleared, and only held ones are read.
`timescale 1ns / 1ps
`default_nettype none

module line_edit_buffer_unit #(
    parameter int LINE_CAPACITY = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lebu_pkg::S_DATA_W-1:0] s_tdata,   // op, code_point, read_index
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lebu_pkg::M_DATA_W-1:0] m_tdata,   // cursor, length, char, took
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lebu_pkg::POS_W-1:0]    cfg_data
);
    import lebu_pkg::*;

    localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [WIDE_W-1:0] CAP_W = WIDE_W'(LINE_CAPACITY);

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [POS_W-1:0]  limit_reg;
    logic [RIDX_W-1:0] walk_cnt_reg, walk_cnt_next;
    logic [CNT_W-1:0]  res_cursor_reg, res_cursor_next;
    logic [CNT_W-1:0]  res_length_reg, res_length_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic              res_took_reg, res_took_next;

    op_t               in_op;
    logic [CHAR_W-1:0] in_cp;
    logic [RIDX_W-1:0] in_ri;
    logic [WIDE_W-1:0] cursor_w, held_w, limit_w, ri_w;
    logic              accept;
    logic              ok_left, ok_right, ok_ins, ok_dl, ok_dr, ok_rd;

    cell_ctrl_t        ctrl [LINE_CAPACITY];
    logic [CHAR_W-1:0] cell_data [LINE_CAPACITY];
    logic [CHAR_W-1:0] cell_tap  [LINE_CAPACITY];

    assign in_op    = op_t'(s_tdata[OP_W-1:0]);
    assign in_cp    = s_tdata[OP_W +: CHAR_W];
    assign in_ri    = s_tdata[OP_W + CHAR_W +: RIDX_W];
    assign cursor_w = WIDE_W'(cursor_reg);
    assign held_w   = WIDE_W'(held_reg);
    assign limit_w  = WIDE_W'(limit_reg);
    assign ri_w     = WIDE_W'(in_ri);
    assign accept   = s_tvalid && s_tready;

    assign ok_left  = cursor_w != '0;
    assign ok_right = cursor_w < held_w;
    assign ok_ins   = (held_w < limit_w) && (held_w < CAP_W);
    assign ok_dl    = cursor_w != '0;
    assign ok_dr    = cursor_w < held_w;
    assign ok_rd    = ri_w < held_w;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_op == OP_READ && ok_rd) ? ST_WALK : ST_RESP;
                end
            end
            ST_WALK: begin
                if (walk_cnt_reg == '0) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_RESP);
    end

    always_comb begin
        cursor_next     = cursor_reg;
        held_next       = held_reg;
        walk_cnt_next   = walk_cnt_reg;
        res_cursor_next = res_cursor_reg;
        res_length_next = res_length_reg;
        res_char_next   = res_char_reg;
        res_took_next   = res_took_reg;
        if (accept) begin
            res_char_next = '0;
            res_took_next = 1'b0;
            case (in_op)
                OP_LEFT: begin
                    if (ok_left) begin
                        cursor_next   = cursor_reg - 1'b1;
                        res_took_next = 1'b1;
                    end
                end
                OP_RIGHT: begin
                    if (ok_right) begin
                        cursor_next   = cursor_reg + 1'b1;
                        res_took_next = 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (ok_ins) begin
                        cursor_next   = cursor_reg + 1'b1;
                        held_next     = held_reg + 1'b1;
                        res_took_next = 1'b1;
                    end
                end
                OP_DEL_LEFT: begin
                    if (ok_dl) begin
                        cursor_next   = cursor_reg - 1'b1;
                        held_next     = held_reg - 1'b1;
                        res_took_next = 1'b1;
                    end
                end
                OP_DEL_RIGHT: begin
                    if (ok_dr) begin
                        held_next     = held_reg - 1'b1;
                        res_took_next = 1'b1;
                    end
                end
                OP_READ: begin
                    walk_cnt_next = in_ri;
                end
                default: begin
                end
            endcase
            res_cursor_next = cursor_next;
            res_length_next = held_next;
        end else if (state_reg == ST_WALK) begin
            if (walk_cnt_reg == '0) begin
                res_char_next = cell_tap[0];
                res_took_next = 1'b1;
            end else begin
                walk_cnt_next = walk_cnt_reg - 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LINE_CAPACITY; i++) begin
            ctrl[i].data_cmd = CMD_HOLD;
            ctrl[i].tap_cmd  = TAP_HOLD;
            if (accept) begin
                case (in_op)
                    OP_INSERT: begin
                        if (ok_ins && WIDE_W'(i) == cursor_w) begin
                            ctrl[i].data_cmd = CMD_LOAD;
                        end else if (ok_ins && WIDE_W'(i) > cursor_w) begin
                            ctrl[i].data_cmd = CMD_LEFT;
                        end
                    end
                    OP_DEL_LEFT: begin
                        if (ok_dl && WIDE_W'(i) >= cursor_w - 1'b1) begin
                            ctrl[i].data_cmd = CMD_RIGHT;
                        end
                    end
                    OP_DEL_RIGHT: begin
                        if (ok_dr && WIDE_W'(i) >= cursor_w) begin
                            ctrl[i].data_cmd = CMD_RIGHT;
                        end
                    end
                    OP_READ: begin
                        ctrl[i].tap_cmd = (WIDE_W'(i) == ri_w) ? TAP_LOAD : TAP_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end else if (state_reg == ST_WALK && walk_cnt_reg != '0) begin
                ctrl[i].tap_cmd = TAP_SHIFT;
            end
        end
    end

    for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
        logic [CHAR_W-1:0] left_d, right_d, right_t;
        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid
            assign left_d = cell_data[g-1];
        end
        if (g == LINE_CAPACITY - 1) begin : g_last
            assign right_d = '0;
            assign right_t = '0;
        end else begin : g_inner
            assign right_d = cell_data[g+1];
            assign right_t = cell_tap[g+1];
        end
        lebu_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[g]),
            .code_point (in_cp),
            .left_data  (left_d),
            .right_data (right_d),
            .right_tap  (right_t),
            .data_out   (cell_data[g]),
            .tap_out    (cell_tap[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            held_reg   <= '0;
            limit_reg  <= LIMIT_RESET;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            held_reg   <= held_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_cnt_reg   <= walk_cnt_next;
        res_cursor_reg <= res_cursor_next;
        res_length_reg <= res_length_next;
        res_char_reg   <= res_char_next;
        res_took_reg   <= res_took_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tdata   = {(M_DATA_W - 2*POS_W - CHAR_W - 1)'(0), res_took_reg, res_char_reg,
                        POS_W'(res_length_reg), POS_W'(res_cursor_reg)};

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= held_reg)
        else $error("cursor beyond line length");

    a_held_in_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        WIDE_W'(held_reg) <= CAP_W)
        else $error("line length beyond capacity");

    a_held_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (held_reg == $past(held_reg) || held_reg == $past(held_reg) + 1'b1
                    || held_reg == $past(held_reg) - 1'b1))
        else $error("line length jumped");

    a_state_frozen_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |=> $stable(held_reg) && $stable(cursor_reg))
        else $error("line changed during read walk");

    a_result_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_cursor_reg <= res_length_reg)
        else $error("result cursor beyond result length");

endmodule

`default_nettype wire

### sv/lebu_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lebu_cell (
    input  wire logic                        aclk,
    input  wire lebu_pkg::cell_ctrl_t        ctrl,
    input  wire logic [lebu_pkg::CHAR_W-1:0] code_point,
    input  wire logic [lebu_pkg::CHAR_W-1:0] left_data,
    input  wire logic [lebu_pkg::CHAR_W-1:0] right_data,
    input  wire logic [lebu_pkg::CHAR_W-1:0] right_tap,
    output logic      [lebu_pkg::CHAR_W-1:0] data_out,
    output logic      [lebu_pkg::CHAR_W-1:0] tap_out
);
    import lebu_pkg::*;

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] tap_reg;

    always_ff @(posedge aclk) begin
        unique case (ctrl.data_cmd)
            CMD_LOAD:  data_reg <= code_point;
            CMD_LEFT:  data_reg <= left_data;
            CMD_RIGHT: data_reg <= right_data;
            default:   data_reg <= data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl.tap_cmd)
            TAP_LOAD:  tap_reg <= data_reg;
            TAP_CLEAR: tap_reg <= '0;
            TAP_SHIFT: tap_reg <= right_tap;
            default:   tap_reg <= tap_reg;
        endcase
    end

    assign data_out = data_reg;
    assign tap_out  = tap_reg;

endmodule

`default_nettype wire

### dv/edit_line_checker.sv
`timescale 1ns / 1ps

module edit_line_checker #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lebu_pkg::S_DATA_W-1:0] s_tdata,   // op, code_point, read_index
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lebu_pkg::M_DATA_W-1:0] m_tdata,   // cursor, length, char, took
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lebu_pkg::POS_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            edits_seen,
    output int                            results_seen,
    output logic [lebu_pkg::POS_W-1:0]    held_now
);
    import lebu_pkg::*;

    typedef struct packed {
        logic              took;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  len;
        logic [POS_W-1:0]  cur;
    } edit_result_t;

    logic [CHAR_W-1:0] line_chars [LINE_CAPACITY];
    logic [POS_W-1:0]  line_len;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  limit;
    edit_result_t      awaited_results[$];
    edit_result_t      want;
    edit_result_t      got;

    initial begin
        fail_count   = 0;
        pending      = 0;
        edits_seen   = 0;
        results_seen = 0;
        held_now     = '0;
    end

    task automatic report_mismatch(input string what, input logic [M_DATA_W-1:0] seen,
                                   input logic [M_DATA_W-1:0] wanted);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
        fail_count++;
    endtask

    function automatic logic [POS_W-1:0] room_limit();
        return (limit < LINE_CAPACITY) ? limit : POS_W'(LINE_CAPACITY);
    endfunction

    task automatic close_gap(input int pos);
        for (int i = pos; i + 1 < line_len; i++) begin
            line_chars[i] = line_chars[i + 1];
        end
        line_len--;
    endtask

    task automatic apply_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] cp,
                              input logic [RIDX_W-1:0] ri, output edit_result_t res);
        logic [CHAR_W-1:0] rd;
        logic              took;
        rd   = '0;
        took = 1'b0;
        case (op)
            OP_LEFT: begin
                if (cursor > 0) begin
                    cursor--;
                    took = 1'b1;
                end
            end
            OP_RIGHT: begin
                if (cursor < line_len) begin
                    cursor++;
                    took = 1'b1;
                end
            end
            OP_INSERT: begin
                if (line_len < room_limit() && cursor <= line_len) begin
                    for (int i = line_len; i > cursor; i--) begin
                        line_chars[i] = line_chars[i - 1];
                    end
                    line_chars[cursor] = cp;
                    line_len++;
                    cursor++;
                    took = 1'b1;
                end
            end
            OP_DEL_LEFT: begin
                if (cursor > 0 && cursor <= line_len) begin
                    close_gap(int'(cursor) - 1);
                    cursor--;
                    took = 1'b1;
                end
            end
            OP_DEL_RIGHT: begin
                if (cursor < line_len) begin
                    close_gap(int'(cursor));
                    took = 1'b1;
                end
            end
            OP_READ: begin
                if (ri < line_len && ri < LINE_CAPACITY) begin
                    rd   = line_chars[ri];
                    took = 1'b1;
                end
            end
            default: ;
        endcase
        res.took = took;
        res.ch   = rd;
        res.len  = line_len;
        res.cur  = cursor;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_len = '0;
            cursor   = '0;
            limit    = LIMIT_RESET;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no edit waiting", m_tdata, '0);
                end else begin
                    want = awaited_results.pop_front();
                    got  = m_tdata[$bits(edit_result_t)-1:0];
                    if (got.cur !== want.cur)
                        report_mismatch("cursor_position", M_DATA_W'(got.cur),
                                        M_DATA_W'(want.cur));
                    if (got.len !== want.len)
                        report_mismatch("line_length", M_DATA_W'(got.len),
                                        M_DATA_W'(want.len));
                    if (got.ch !== want.ch)
                        report_mismatch("read_char", M_DATA_W'(got.ch), M_DATA_W'(want.ch));
                    if (got.took !== want.took)
                        report_mismatch("took_effect", M_DATA_W'(got.took),
                                        M_DATA_W'(want.took));
                    results_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                limit = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                apply_edit(s_tdata[OP_W-1:0], s_tdata[OP_W+CHAR_W-1:OP_W],
                           s_tdata[OP_W+CHAR_W+RIDX_W-1:OP_W+CHAR_W], want);
                awaited_results.push_back(want);
                edits_seen++;
            end
        end
        pending  = awaited_results.size();
        held_now = line_len;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import lebu_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // op, code_point, read_index
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // cursor, length, char, took
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [POS_W-1:0]    cfg_data  = '0;

    int               send_idle  = 0;
    int               recv_stall = 0;
    int               fail_count;
    int               pending;
    int               edits_seen;
    int               results_seen;
    logic [POS_W-1:0] held_now;

    line_edit_buffer_unit #(.LINE_CAPACITY(64)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    edit_line_checker #(.LINE_CAPACITY(64)) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .edits_seen   (edits_seen),
        .results_seen (results_seen),
        .held_now     (held_now)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL line_edit_buffer_unit");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic send_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] cp,
                             input logic [RIDX_W-1:0] ri);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ri, cp, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle_line();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct) return OP_INSERT;
        if ($urandom_range(0, 99) < 3)
            return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
        case ($urandom_range(0, 4))
            0:       return OP_LEFT;
            1:       return OP_RIGHT;
            2:       return OP_DEL_LEFT;
            3:       return OP_DEL_RIGHT;
            default: return OP_READ;
        endcase
    endfunction

    task automatic run_phase(input logic [POS_W-1:0] limit, input int idle_pct,
                             input int stall_pct, input int count, input int insert_pct);
        logic [OP_W-1:0]   op;
        logic [RIDX_W-1:0] ri;
        settle_line();
        write_limit(limit);
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        repeat (count) begin
            op = pick_op(insert_pct);
            // aim most reads at held characters
            if (held_now != 0 && $urandom_range(0, 3) != 0)
                ri = RIDX_W'($urandom_range(0, int'(held_now) - 1));
            else
                ri = RIDX_W'($urandom_range(0, 63));
            send_edit(op, CHAR_W'($urandom_range(0, 21'h1FFFFF)), ri);
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty line: moves, deletes and reads all miss
        send_edit(OP_LEFT, '0, '0);
        send_edit(OP_RIGHT, '0, '0);
        send_edit(OP_DEL_LEFT, '0, '0);
        send_edit(OP_DEL_RIGHT, '0, '0);
        send_edit(OP_READ, '0, '0);
        send_edit(OP_SPARE_LO, 21'h1FFFFF, 6'h3F);
        send_edit(OP_SPARE_HI, 21'h1FFFFF, 6'h3F);
        // extremes of the code point and the top of the Unicode range
        send_edit(OP_INSERT, 21'h000000, '0);
        send_edit(OP_INSERT, 21'h1FFFFF, '0);
        send_edit(OP_INSERT, 21'h10FFFF, '0);
        send_edit(OP_LEFT, '0, '0);
        send_edit(OP_LEFT, '0, '0);
        send_edit(OP_INSERT, 21'h000041, '0);
        send_edit(OP_READ, '0, 6'd0);
        send_edit(OP_READ, '0, 6'd1);
        send_edit(OP_READ, '0, 6'd3);
        send_edit(OP_READ, '0, 6'd4);
        send_edit(OP_READ, 21'h1FFFFF, 6'h3F);
        send_edit(OP_RIGHT, '0, '0);
        send_edit(OP_RIGHT, '0, '0);
        send_edit(OP_RIGHT, '0, '0);
        send_edit(OP_DEL_RIGHT, '0, '0);
        send_edit(OP_DEL_LEFT, '0, '0);
        send_edit(OP_LEFT, '0, '0);
        send_edit(OP_DEL_RIGHT, '0, '0);

        run_phase(7'd64, 0, 0, 200, 45);
        run_phase(7'd127, 83, 0, 150, 55);
        run_phase(7'd1, 0, 83, 120, 30);
        run_phase(7'd0, 20, 20, 80, 30);
        run_phase(7'd17, 0, 0, 130, 40);
        run_phase(7'd64, 20, 20, 150, 35);

        settle_line();
        repeat (70) @(negedge aclk);

        $display("Covered %0d edits and %0d checked results with limits 0, 1, 17, 64 and 127,",
                 edits_seen, results_seen);
        $display("idle gaps and back-pressure on both channels; %0d mismatches", fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS line_edit_buffer_unit");
        end else begin
            $display("FAIL line_edit_buffer_unit");
        end
        $finish;
    end

endmodule
